// ===== rtl/atclp_pkg.sv =====
// Package: shared types, character codes and helpers of the AT command line parser.
`default_nettype none
package atclp_pkg;

   localparam int LINE_MAX = 255;
   localparam int POS_W    = $clog2(LINE_MAX + 1);
   localparam int Q_DEPTH  = 2;
   localparam int QPTR_W   = $clog2(Q_DEPTH);
   localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [23:0] NUM_LIMIT  = 24'd1000000;
   localparam logic [23:0] PLUS_LIMIT = 24'd10000000;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam logic [2:0] KIND_CMD    = 3'd0;
   localparam logic [2:0] KIND_NAME   = 3'd1;
   localparam logic [2:0] KIND_ARG    = 3'd2;
   localparam logic [2:0] KIND_MOD    = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   localparam logic [1:0] PRE_NONE = 2'd0;
   localparam logic [1:0] PRE_AMP  = 2'd1;
   localparam logic [1:0] PRE_PLUS = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ERROR  = 2'd1;
   localparam logic [1:0] ST_REPEAT = 2'd2;

   localparam logic [1:0] REP_NONE  = 2'd0;
   localparam logic [1:0] REP_A     = 2'd1;
   localparam logic [1:0] REP_SLASH = 2'd2;

   typedef enum logic [4:0] {
      M_LEAD_A, M_LEAD_T, M_IDLE, M_PLUS_FIRST, M_PLUS_NAME, M_PLUS_VAL0,
      M_PLUS_VAL, M_AMP, M_S_NUM0, M_S_NUM, M_S_VAL0, M_S_VAL, M_P_NUM,
      M_P_EQ, M_P_QUOTE, M_P_AFTERQ, M_P_MODS, M_D_MODS, M_D_QUOTE,
      M_D_DIGITS, M_SUFFIX, M_ERROR
   } mode_type;

   typedef struct packed {
      logic       func;
      logic [7:0] in_char;
   } req_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [1:0]  prefix_code;
      logic [6:0]  verb_letter;
      logic [7:0]  text_char;
      logic [19:0] reg_number;
      logic [23:0] set_value;
      logic        has_assign;
      logic        has_query;
      logic [1:0]  line_status;
      logic [7:0]  err_position;
      logic        last_flag;
   } rsp_type;

   // results of one accepted beat, at most two records
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r1;
      rsp_type    r0;
   } bundle_type;

   function automatic rsp_type mk_text(logic [2:0] kind, logic [1:0] pre, logic [6:0] verb,
                                       logic [7:0] text);
      rsp_type r;
      r = '0;
      r.record_kind = kind;
      r.prefix_code = pre;
      r.verb_letter = verb;
      r.text_char   = text;
      return r;
   endfunction

   function automatic rsp_type mk_cmd(logic [1:0] pre, logic [6:0] verb, logic [19:0] num,
                                      logic [23:0] val, logic asg, logic qry);
      rsp_type r;
      r = '0;
      r.record_kind = KIND_CMD;
      r.prefix_code = pre;
      r.verb_letter = verb;
      r.reg_number  = num;
      r.set_value   = val;
      r.has_assign  = asg;
      r.has_query   = qry;
      return r;
   endfunction

   function automatic rsp_type mk_status(logic [1:0] st, logic [7:0] epos);
      rsp_type r;
      r = '0;
      r.record_kind  = KIND_STATUS;
      r.line_status  = st;
      r.err_position = epos;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/atclp_front.sv =====
// Front end: accepts characters, tracks the parse state and builds the records of each beat.
`default_nettype none
module atclp_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  atclp_pkg::req_type   req_data,
   output atclp_pkg::bundle_type bundle,
   output logic                 push
);
   import atclp_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in, start_ff, start_in, quote_ff, quote_in;
   logic [1:0]        prefix_ff, prefix_in, rep_ff, rep_in;
   logic [6:0]        verb_ff, verb_in;
   logic [19:0]       num_ff, num_in;
   logic [23:0]       val_ff, val_in;
   logic              assign_ff, assign_in, query_ff, query_in, errv_ff, errv_in;
   logic [7:0]        errat_ff, errat_in;

   logic [7:0]        c, m;
   logic              dig, alp, an, blank;
   logic              do_start, do_verb, fail_req;
   logic [POS_W-1:0]  fail_pos;
   logic [7:0]        fail_sat;

   function automatic logic [7:0] upc(logic [7:0] x);
      return (x >= 8'h61 && x <= 8'h7A) ? x - 8'd32 : x;
   endfunction

   function automatic logic [7:0] sat_pos(logic [POS_W-1:0] v);
      return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
   endfunction

   // one decimal digit into a clamped accumulator
   function automatic logic [23:0] acc(logic [23:0] x, logic [3:0] d, logic [23:0] lim);
      logic [27:0] t;
      t = {x, 3'b000} + {3'b000, x, 1'b0} + 28'(d);
      return (t > 28'(lim)) ? lim : t[23:0];
   endfunction

   function automatic logic takes_number(logic [1:0] pre, logic [6:0] v);
      logic r;
      if (pre == PRE_AMP) begin
         case (v) inside
            7'h43, 7'h44, 7'h4B, 7'h47, 7'h51, 7'h52, 7'h54, 7'h57, 7'h46, 7'h56: r = 1'b1;
            default: r = 1'b0;
         endcase
      end else begin
         case (v) inside
            7'h42, 7'h4C, 7'h4D, 7'h4E, 7'h57, 7'h59, 7'h45, 7'h51, 7'h56, 7'h58,
            7'h5A, 7'h4F, 7'h48, 7'h49, 7'h41: r = 1'b1;
            default: r = 1'b0;
         endcase
      end
      return r;
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_LEAD_A;
         pos_ff    <= '0;
         start_ff  <= '0;
         quote_ff  <= '0;
         prefix_ff <= PRE_NONE;
         verb_ff   <= '0;
         num_ff    <= '0;
         val_ff    <= '0;
         assign_ff <= 1'b0;
         query_ff  <= 1'b0;
         errv_ff   <= 1'b0;
         errat_ff  <= '0;
         rep_ff    <= REP_NONE;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         quote_ff  <= quote_in;
         prefix_ff <= prefix_in;
         verb_ff   <= verb_in;
         num_ff    <= num_in;
         val_ff    <= val_in;
         assign_ff <= assign_in;
         query_ff  <= query_in;
         errv_ff   <= errv_in;
         errat_ff  <= errat_in;
         rep_ff    <= rep_in;
      end
   end

   // parse step
   always_comb begin
      mode_in = mode_ff; pos_in = pos_ff; start_in = start_ff; quote_in = quote_ff;
      prefix_in = prefix_ff; verb_in = verb_ff; num_in = num_ff; val_in = val_ff;
      assign_in = assign_ff; query_in = query_ff; errv_in = errv_ff; errat_in = errat_ff;
      rep_in = rep_ff;
      bundle = '0;
      do_start = 1'b0; do_verb = 1'b0; fail_req = 1'b0; fail_pos = '0;
      c = req_data.in_char;
      m = upc(c);
      dig = (c >= 8'h30) && (c <= 8'h39);
      alp = (m >= 8'h41) && (m <= 8'h5A);
      an = alp || dig;
      blank = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
      fail_sat = '0;

      if (accept && req_data.func) begin
         // end of line
         case (mode_ff)
            M_LEAD_A, M_LEAD_T: begin fail_req = 1'b1; fail_pos = '0; end
            M_PLUS_FIRST, M_AMP, M_S_NUM0: begin fail_req = 1'b1; fail_pos = start_ff; end
            M_PLUS_VAL0, M_S_NUM, M_S_VAL0: begin fail_req = 1'b1; fail_pos = pos_ff; end
            M_P_QUOTE, M_D_QUOTE: begin fail_req = 1'b1; fail_pos = quote_ff; end
            M_PLUS_NAME, M_PLUS_VAL, M_S_VAL, M_P_NUM, M_P_EQ, M_P_AFTERQ, M_P_MODS,
            M_D_MODS, M_D_DIGITS, M_SUFFIX: begin
               bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
               bundle.count = 2'd1;
            end
            default: ;
         endcase
         fail_sat = sat_pos(fail_pos);
         if (rep_ff == REP_SLASH) begin
            bundle.r0 = mk_status(ST_REPEAT, '0);
            bundle.count = 2'd1;
         end else if (bundle.count == 2'd1) begin
            bundle.r1 = (errv_ff || fail_req) ?
                        mk_status(ST_ERROR, fail_req ? fail_sat : errat_ff) :
                        mk_status(ST_OK, '0);
            bundle.count = 2'd2;
         end else begin
            bundle.r0 = (errv_ff || fail_req) ?
                        mk_status(ST_ERROR, fail_req ? fail_sat : errat_ff) :
                        mk_status(ST_OK, '0);
            bundle.count = 2'd1;
         end
         mode_in = M_LEAD_A; pos_in = '0; start_in = '0; quote_in = '0;
         prefix_in = PRE_NONE; verb_in = '0; num_in = '0; val_in = '0;
         assign_in = 1'b0; query_in = 1'b0; errv_in = 1'b0; errat_in = '0;
         rep_in = REP_NONE;
      end else if (accept && (pos_ff < POS_W'(LINE_MAX))) begin
         // repeat line tracking
         if (pos_ff == '0) rep_in = (m == CH_A) ? REP_A : REP_NONE;
         else if (pos_ff == POS_W'(1))
            rep_in = (rep_ff == REP_A && c == CH_SLASH) ? REP_SLASH : REP_NONE;
         else rep_in = REP_NONE;

         case (mode_ff)
            M_LEAD_A: if (m == CH_A) mode_in = M_LEAD_T; else fail_req = 1'b1;
            M_LEAD_T: if (m == CH_T) mode_in = M_IDLE; else fail_req = 1'b1;
            M_IDLE: do_start = 1'b1;
            M_PLUS_FIRST: begin
               if (an) begin
                  bundle.r0 = mk_text(KIND_NAME, prefix_ff, verb_ff, m);
                  bundle.count = 2'd1;
                  mode_in = M_PLUS_NAME;
               end else begin fail_req = 1'b1; fail_pos = start_ff; end
            end
            M_PLUS_NAME: begin
               if (an) begin
                  bundle.r0 = mk_text(KIND_NAME, prefix_ff, verb_ff, m);
                  bundle.count = 2'd1;
               end else if (c == CH_EQ) begin
                  assign_in = 1'b1; mode_in = M_PLUS_VAL0;
               end else if (c == CH_QUERY) begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, 1'b1);
                  bundle.count = 2'd1;
                  query_in = 1'b1; mode_in = M_IDLE;
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_PLUS_VAL0: begin
               if (dig) begin
                  val_in = acc('0, c[3:0], PLUS_LIMIT); mode_in = M_PLUS_VAL;
               end else begin fail_req = 1'b1; fail_pos = pos_ff; end
            end
            M_PLUS_VAL, M_S_VAL: begin
               if (dig) begin
                  val_in = acc(val_ff, c[3:0], (mode_ff == M_PLUS_VAL) ? PLUS_LIMIT : NUM_LIMIT);
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_AMP: begin
               if (alp) do_verb = 1'b1;
               else begin fail_req = 1'b1; fail_pos = start_ff; end
            end
            M_S_NUM0: begin
               if (dig) begin
                  num_in = 20'(acc('0, c[3:0], NUM_LIMIT)); mode_in = M_S_NUM;
               end else begin fail_req = 1'b1; fail_pos = start_ff; end
            end
            M_S_NUM: begin
               if (dig) num_in = 20'(acc(24'(num_ff), c[3:0], NUM_LIMIT));
               else if (c == CH_EQ) begin assign_in = 1'b1; mode_in = M_S_VAL0; end
               else if (c == CH_QUERY) begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, 1'b1);
                  bundle.count = 2'd1;
                  query_in = 1'b1; mode_in = M_IDLE;
               end else begin fail_req = 1'b1; fail_pos = pos_ff; end
            end
            M_S_VAL0: begin
               if (dig) begin
                  val_in = acc('0, c[3:0], NUM_LIMIT); mode_in = M_S_VAL;
               end else begin fail_req = 1'b1; fail_pos = pos_ff; end
            end
            M_P_NUM, M_SUFFIX: begin
               if (dig) num_in = 20'(acc(24'(num_ff), c[3:0], NUM_LIMIT));
               else if (mode_ff == M_P_NUM && c == CH_EQ) begin
                  assign_in = 1'b1; mode_in = M_P_EQ;
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_P_EQ: begin
               if (c == CH_QUOTE) begin quote_in = pos_ff; mode_in = M_P_QUOTE; end
               else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_P_QUOTE: begin
               if (c == CH_QUOTE) mode_in = M_P_AFTERQ;
               else begin
                  bundle.r0 = mk_text(KIND_ARG, prefix_ff, verb_ff, c);
                  bundle.count = 2'd1;
               end
            end
            M_P_AFTERQ: begin
               if (c == CH_COMMA) mode_in = M_P_MODS;
               else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_P_MODS: begin
               if (alp) begin
                  if (m == CH_T || m == CH_E) begin
                     bundle.r0 = mk_text(KIND_MOD, prefix_ff, verb_ff, m);
                     bundle.count = 2'd1;
                  end else begin fail_req = 1'b1; fail_pos = pos_ff; end
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_D_MODS: begin
               if (alp) begin
                  if (m == CH_T || m == CH_E) begin
                     bundle.r0 = mk_text(KIND_MOD, prefix_ff, verb_ff, m);
                     bundle.count = 2'd1;
                  end else if (m != CH_P) begin fail_req = 1'b1; fail_pos = pos_ff; end
               end else if (c == CH_QUOTE) begin
                  quote_in = pos_ff; mode_in = M_D_QUOTE;
               end else if (dig) begin
                  bundle.r0 = mk_text(KIND_ARG, prefix_ff, verb_ff, c);
                  bundle.count = 2'd1;
                  mode_in = M_D_DIGITS;
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            M_D_QUOTE: begin
               if (c == CH_QUOTE) begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  bundle.r0 = mk_text(KIND_ARG, prefix_ff, verb_ff, c);
                  bundle.count = 2'd1;
               end
            end
            M_D_DIGITS: begin
               if (dig) begin
                  bundle.r0 = mk_text(KIND_ARG, prefix_ff, verb_ff, c);
                  bundle.count = 2'd1;
               end else begin
                  bundle.r0 = mk_cmd(prefix_ff, verb_ff, num_ff, val_ff, assign_ff, query_ff);
                  bundle.count = 2'd1;
                  mode_in = M_IDLE; do_start = 1'b1;
               end
            end
            default: ;
         endcase

         // new command begins on this character
         if (do_start && !blank) begin
            start_in = pos_ff;
            num_in = '0; val_in = '0; assign_in = 1'b0; query_in = 1'b0; verb_in = '0;
            if (c == CH_PLUS) begin prefix_in = PRE_PLUS; mode_in = M_PLUS_FIRST; end
            else if (c == CH_AMP) begin prefix_in = PRE_AMP; mode_in = M_AMP; end
            else if (alp) begin prefix_in = PRE_NONE; do_verb = 1'b1; end
            else begin fail_req = 1'b1; fail_pos = pos_ff; end
         end

         // verb letter picks the command form
         if (do_verb) begin
            verb_in = m[6:0];
            if (m == CH_S) mode_in = M_S_NUM0;
            else if (prefix_in == PRE_NONE && m == CH_P) mode_in = M_P_NUM;
            else if (prefix_in == PRE_NONE && m == CH_D) mode_in = M_D_MODS;
            else if (takes_number(prefix_in, m[6:0])) mode_in = M_SUFFIX;
            else begin fail_req = 1'b1; fail_pos = start_in; end
         end

         if (fail_req) begin
            errv_in = 1'b1; errat_in = sat_pos(fail_pos); mode_in = M_ERROR;
         end
         pos_in = pos_ff + POS_W'(1);
      end
      push = accept && (bundle.count != 2'd0);
   end

endmodule
`default_nettype wire

// ===== rtl/atclp_queue.sv =====
// Short queue of record bundles between the parser front and the output back end.
`default_nettype none
module atclp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  atclp_pkg::bundle_type wr_data,
   input  wire                   pop,
   output atclp_pkg::bundle_type rd_data,
   output logic                  full,
   output logic                  not_empty
);
   import atclp_pkg::*;

   bundle_type         mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] nxt(logic [QPTR_W-1:0] p);
      return (32'(p) == Q_DEPTH - 1) ? '0 : p + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // pointer and fill tracking
   always_comb begin
      wr_in  = push ? nxt(wr_ff) : wr_ff;
      rd_in  = pop ? nxt(rd_ff) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign rd_data   = mem_ff[rd_ff];
   assign full      = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign not_empty = (cnt_ff != '0);

endmodule
`default_nettype wire

// ===== rtl/atclp_back.sv =====
// Back end: takes bundles off the queue and presents their records one beat at a time.
`default_nettype none
module atclp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_not_empty,
   input  atclp_pkg::bundle_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output atclp_pkg::rsp_type    rsp_data
);
   import atclp_pkg::*;

   bundle_type cur_ff, cur_in;
   logic       idx_ff, idx_in, valid_ff, valid_in;
   logic       finishing, taken;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // step through the records of the held bundle
   always_comb begin
      finishing = idx_ff || (cur_ff.count == 2'd1);
      taken     = valid_ff && !rsp_stall;
      q_pop     = q_not_empty && (!valid_ff || (taken && finishing));
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      if (q_pop) begin
         cur_in   = q_data;
         idx_in   = 1'b0;
         valid_in = 1'b1;
      end else if (taken && finishing) begin
         valid_in = 1'b0;
      end else if (taken) begin
         idx_in = 1'b1;
      end
      rsp_data = idx_ff ? cur_ff.r1 : cur_ff.r0;
      rsp_data.last_flag = finishing;
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/at_command_line_parser_unit.sv =====
// Top level of the AT command line parser: front parser, bundle queue and output stage.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | func, in_char
//   rsp_    | out       | rsp_valid/rsp_stall | one record per beat
//
// A character beat is parsed in the cycle it is accepted; one beat per cycle is
// taken while the two-entry bundle queue has room. The output stage presents one
// record per beat, so a beat that makes two records occupies it for both of them.
// Synchronous reset returns the parser to the line lead-in and empties the queue.
// req_stall rises only when the queue is full; rsp_stall holds the current record.
`default_nettype none
module at_command_line_parser_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  atclp_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output atclp_pkg::rsp_type  rsp_data
);
   import atclp_pkg::*;

   bundle_type f_bundle, q_data;
   logic       f_push, q_full, q_not_empty, q_pop, accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   atclp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .bundle   (f_bundle),
      .push     (f_push)
   );

   atclp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .wr_data   (f_bundle),
      .pop       (q_pop),
      .rd_data   (q_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   atclp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/at_command_line_parser_unit_test.sv =====
// Testbench of the AT command line parser: directed and random command lines against a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module at_command_line_parser_unit_test;
   import atclp_pkg::*;

   typedef struct {
      req_type beat;
      bit      drain;     // wait for all results before offering this beat
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_type pending_beats[$];
   rsp_type     expected_records[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          lines_seen = 0, commands_seen = 0, error_lines = 0, repeat_lines = 0;
   bit          req_took = 1'b0;

   at_command_line_parser_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- parser predictor ----------------
   mode_type   pmode;
   int         cpos, cmd_pos, quote_mark, num_acc, val_acc, err_at;
   logic [1:0] cur_pre, rep_track;
   logic [6:0] cur_verb;
   bit         f_asg, f_qry, err_seen;
   rsp_type    step_recs[2];
   int         step_count;

   function automatic logic [7:0] upc(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction
   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_let(logic [7:0] c);
      return upc(c) >= "A" && upc(c) <= "Z";
   endfunction
   function automatic bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction
   function automatic int accum(int x, logic [7:0] c, int lim);
      x = x * 10 + (c - 8'h30);
      return x > lim ? lim : x;
   endfunction

   function automatic void clear_parser();
      pmode = M_LEAD_A;
      cpos = 0; cmd_pos = 0; quote_mark = 0; num_acc = 0; val_acc = 0; err_at = 0;
      cur_pre = PRE_NONE; cur_verb = '0; rep_track = REP_NONE;
      f_asg = 0; f_qry = 0; err_seen = 0;
   endfunction

   function automatic void put_record(logic [2:0] kind, logic [7:0] text);
      rsp_type r;
      if (step_count >= 2) return;
      r = '0;
      r.record_kind = kind;
      r.prefix_code = cur_pre;
      r.verb_letter = cur_verb;
      r.text_char   = text;
      if (kind == KIND_CMD) begin
         r.reg_number = num_acc[19:0];
         r.set_value  = val_acc[23:0];
         r.has_assign = f_asg;
         r.has_query  = f_qry;
      end
      step_recs[step_count++] = r;
   endfunction

   function automatic void put_status(logic [1:0] st, int epos);
      rsp_type r;
      if (step_count >= 2) return;
      r = '0;
      r.record_kind  = KIND_STATUS;
      r.line_status  = st;
      r.err_position = epos[7:0];
      step_recs[step_count++] = r;
   endfunction

   function automatic void latch_error(int p);
      err_seen = 1;
      err_at = p > 255 ? 255 : p;
      pmode = M_ERROR;
   endfunction

   function automatic void finish_cmd();
      put_record(KIND_CMD, 8'h00);
      pmode = M_IDLE;
   endfunction

   function automatic bit wants_number(logic [1:0] pre, logic [7:0] v);
      if (pre == PRE_AMP)
         return v inside {"C", "D", "K", "G", "Q", "R", "T", "W", "F", "V"};
      return v inside {"B", "L", "M", "N", "W", "Y", "E", "Q", "V", "X", "Z", "O", "H", "I",
                       "A"};
   endfunction

   function automatic void take_verb(logic [7:0] c);
      logic [7:0] v;
      v = upc(c);
      cur_verb = v[6:0];
      if (v == CH_S) pmode = M_S_NUM0;
      else if (cur_pre == PRE_NONE && v == CH_P) pmode = M_P_NUM;
      else if (cur_pre == PRE_NONE && v == CH_D) pmode = M_D_MODS;
      else if (wants_number(cur_pre, v)) pmode = M_SUFFIX;
      else latch_error(cmd_pos);
   endfunction

   function automatic void open_cmd(logic [7:0] c);
      if (is_blank(c)) return;
      cmd_pos = cpos;
      num_acc = 0; val_acc = 0; f_asg = 0; f_qry = 0; cur_verb = '0;
      if (c == CH_PLUS) begin
         cur_pre = PRE_PLUS; pmode = M_PLUS_FIRST;
      end else if (c == CH_AMP) begin
         cur_pre = PRE_AMP; pmode = M_AMP;
      end else if (is_let(c)) begin
         cur_pre = PRE_NONE; take_verb(c);
      end else latch_error(cpos);
   endfunction

   function automatic void parse_char(logic [7:0] c);
      logic [7:0] m;
      bit d, an;
      m = upc(c); d = is_dig(c); an = is_let(c) || d;
      case (pmode)
         M_LEAD_A: if (m == CH_A) pmode = M_LEAD_T; else latch_error(0);
         M_LEAD_T: if (m == CH_T) pmode = M_IDLE; else latch_error(0);
         M_IDLE: open_cmd(c);
         M_PLUS_FIRST: begin
            if (an) begin
               put_record(KIND_NAME, m); pmode = M_PLUS_NAME;
            end else latch_error(cmd_pos);
         end
         M_PLUS_NAME: begin
            if (an) put_record(KIND_NAME, m);
            else if (c == CH_EQ) begin
               f_asg = 1; pmode = M_PLUS_VAL0;
            end else if (c == CH_QUERY) begin
               f_qry = 1; finish_cmd();
            end else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_PLUS_VAL0: begin
            if (d) begin
               val_acc = accum(0, c, PLUS_LIMIT); pmode = M_PLUS_VAL;
            end else latch_error(cpos);
         end
         M_PLUS_VAL: begin
            if (d) val_acc = accum(val_acc, c, PLUS_LIMIT);
            else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_AMP: if (is_let(c)) take_verb(c); else latch_error(cmd_pos);
         M_S_NUM0: begin
            if (d) begin
               num_acc = accum(0, c, NUM_LIMIT); pmode = M_S_NUM;
            end else latch_error(cmd_pos);
         end
         M_S_NUM: begin
            if (d) num_acc = accum(num_acc, c, NUM_LIMIT);
            else if (c == CH_EQ) begin
               f_asg = 1; pmode = M_S_VAL0;
            end else if (c == CH_QUERY) begin
               f_qry = 1; finish_cmd();
            end else latch_error(cpos);
         end
         M_S_VAL0: begin
            if (d) begin
               val_acc = accum(0, c, NUM_LIMIT); pmode = M_S_VAL;
            end else latch_error(cpos);
         end
         M_S_VAL: begin
            if (d) val_acc = accum(val_acc, c, NUM_LIMIT);
            else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_P_NUM: begin
            if (d) num_acc = accum(num_acc, c, NUM_LIMIT);
            else if (c == CH_EQ) begin
               f_asg = 1; pmode = M_P_EQ;
            end else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_P_EQ: begin
            if (c == CH_QUOTE) begin
               quote_mark = cpos; pmode = M_P_QUOTE;
            end else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_P_QUOTE: if (c == CH_QUOTE) pmode = M_P_AFTERQ; else put_record(KIND_ARG, c);
         M_P_AFTERQ: begin
            if (c == CH_COMMA) pmode = M_P_MODS;
            else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_P_MODS: begin
            if (is_let(c)) begin
               if (m == CH_T || m == CH_E) put_record(KIND_MOD, m); else latch_error(cpos);
            end else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_D_MODS: begin
            if (is_let(c)) begin
               if (m == CH_T || m == CH_E) put_record(KIND_MOD, m);
               else if (m != CH_P) latch_error(cpos);
            end else if (c == CH_QUOTE) begin
               quote_mark = cpos; pmode = M_D_QUOTE;
            end else if (d) begin
               put_record(KIND_ARG, c); pmode = M_D_DIGITS;
            end else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_D_QUOTE: if (c == CH_QUOTE) finish_cmd(); else put_record(KIND_ARG, c);
         M_D_DIGITS: begin
            if (d) put_record(KIND_ARG, c);
            else begin
               finish_cmd(); open_cmd(c);
            end
         end
         M_SUFFIX: begin
            if (d) num_acc = accum(num_acc, c, NUM_LIMIT);
            else begin
               finish_cmd(); open_cmd(c);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_eol();
      case (pmode)
         M_LEAD_A, M_LEAD_T: latch_error(0);
         M_PLUS_FIRST, M_AMP, M_S_NUM0: latch_error(cmd_pos);
         M_PLUS_VAL0, M_S_NUM, M_S_VAL0: latch_error(cpos);
         M_P_QUOTE, M_D_QUOTE: latch_error(quote_mark);
         M_PLUS_NAME, M_PLUS_VAL, M_S_VAL, M_P_NUM, M_P_EQ, M_P_AFTERQ, M_P_MODS,
         M_D_MODS, M_D_DIGITS, M_SUFFIX: finish_cmd();
         default: ;
      endcase
      if (rep_track == REP_SLASH) begin
         step_count = 0; put_status(ST_REPEAT, 0);
      end else if (err_seen) put_status(ST_ERROR, err_at);
      else put_status(ST_OK, 0);
   endfunction

   // predict the records of one accepted beat and queue them
   function automatic void predict_records(req_type b);
      step_count = 0;
      if (b.func) begin
         parse_eol();
         clear_parser();
      end else if (cpos < LINE_MAX) begin
         if (cpos == 0) rep_track = (upc(b.in_char) == CH_A) ? REP_A : REP_NONE;
         else if (cpos == 1)
            rep_track = (rep_track == REP_A && b.in_char == CH_SLASH) ? REP_SLASH : REP_NONE;
         else rep_track = REP_NONE;
         parse_char(b.in_char);
         cpos++;
      end
      for (int k = 0; k < step_count; k++) begin
         step_recs[k].last_flag = (k == step_count - 1);
         expected_records = {expected_records, step_recs[k]};
      end
   endfunction

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // ---------------- monitor: accept beats, check records ----------------
   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            predict_records(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) report_mismatch("unexpected", rsp_data, '0);
            else begin
               rsp_type want;
               want = expected_records.pop_front();
               if (rsp_data !== want) report_mismatch("record", rsp_data, want);
               if (want.record_kind == KIND_CMD) commands_seen++;
               if (want.record_kind == KIND_STATUS) begin
                  lines_seen++;
                  if (want.line_status == ST_ERROR) error_lines++;
                  if (want.line_status == ST_REPEAT) repeat_lines++;
               end
            end
         end
         // watchdog on cycles without any beat
         if (req_took || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("watchdog expired, %0d records outstanding", expected_records.size());
            $display("[at_command_line_parser_unit] ERROR");
            $finish;
         end
      end
   end

   // ---------------- driver: bursts and gaps ----------------
   int burst_left = 0, gap_left = 0;
   pending_type next_item;
   always @(negedge clock) begin
      if (reset) req_valid <= 1'b0;
      else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0 &&
                      !(pending_beats[0].drain && expected_records.size() != 0)) begin
            next_item = pending_beats.pop_front();
            req_data  <= next_item.beat;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left--;
         end else req_valid <= 1'b0;
      end
   end

   // ---------------- receiver stall pattern ----------------
   int rx_cycle = 0, rx_hold = 0;
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle == 600 || rx_cycle == 1500) rx_hold = 400;
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1'b1;
      end else begin
         case ((rx_cycle / 64) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= rx_cycle[0];
         endcase
      end
   end

   // ---------------- stimulus ----------------
   int beats_made = 0;

   task automatic push_char(logic [7:0] c, bit drain = 0);
      pending_type p;
      p.beat.func = 1'b0; p.beat.in_char = c; p.drain = drain;
      pending_beats = {pending_beats, p};
      beats_made++;
   endtask

   task automatic push_eol();
      pending_type p;
      p.beat.func = 1'b1; p.beat.in_char = 8'($urandom_range(0, 255)); p.drain = 0;
      pending_beats = {pending_beats, p};
      beats_made++;
   endtask

   task automatic push_text(string s);
      foreach (s[i]) push_char(s[i]);
   endtask

   task automatic push_digits(int n);
      repeat (n) push_char(8'("0" + $urandom_range(0, 9)));
   endtask

   task automatic push_pick(string s);
      push_char(s[$urandom_range(0, s.len() - 1)]);
   endtask

   // one random command, mostly well formed
   task automatic push_command();
      case ($urandom_range(0, 9))
         0, 1: begin
            push_char("+");
            repeat ($urandom_range(1, 6))
               push_pick("abcxyzABCGMQ0123456789");
            case ($urandom_range(0, 2))
               0: ;
               1: begin push_char("="); push_digits($urandom_range(1, 9)); end
               default: push_char("?");
            endcase
         end
         2: begin
            push_char("&");
            push_pick("CDKGQRTWFVcdkqSsAx");
            push_digits($urandom_range(0, 3));
         end
         3: begin
            push_pick("Ss");
            push_digits($urandom_range(1, 8));
            if ($urandom_range(0, 1)) begin
               push_char("="); push_digits($urandom_range(1, 8));
            end else push_char("?");
         end
         4: begin
            push_pick("Pp");
            push_digits($urandom_range(0, 8));
            if ($urandom_range(0, 3) != 0) begin
               push_char("=");
               if ($urandom_range(0, 3) != 0) begin
                  push_char(CH_QUOTE);
                  repeat ($urandom_range(0, 5)) push_char(8'($urandom_range(32, 126)));
                  if ($urandom_range(0, 7) != 0) push_char(CH_QUOTE);
                  if ($urandom_range(0, 1)) begin
                     push_char(",");
                     repeat ($urandom_range(0, 3)) push_pick("TEteTEx");
                  end
               end
            end
         end
         5: begin
            push_pick("Dd");
            repeat ($urandom_range(0, 3)) push_pick("TEPtepTEPq");
            if ($urandom_range(0, 1)) begin
               push_char(CH_QUOTE);
               repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(0, 255)));
               if ($urandom_range(0, 7) != 0) push_char(CH_QUOTE);
            end else push_digits($urandom_range(0, 7));
         end
         6, 7: begin
            push_pick("BLMNWYEQVXZOHIAblmnwyeqvxzohia");
            push_digits($urandom_range(0, 8));
         end
         8: push_pick(" \t\r\n");
         default: push_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic push_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) push_text($urandom_range(0, 1) ? "A/" : "a/");
      else if (pick < 10) repeat ($urandom_range(0, 4)) push_char(8'($urandom_range(0, 255)));
      else if (pick < 11) begin
         // overlong line: characters past the limit are dropped
         push_text("ATZ");
         push_digits($urandom_range(255, 300));
      end else begin
         push_pick("Aa"); push_pick("Tt");
         repeat ($urandom_range(0, 6)) push_command();
      end
      push_eol();
   endtask

   initial begin
      clear_parser();
      // directed lines: repeat line, clamps, modifiers, unclosed quote, bad lead-in
      push_text("a/"); push_eol();
      push_text("AT+c=99999999"); push_eol();
      push_text("ATs1=9999999?"); push_eol();
      push_text("ATdTp\"5"); push_eol();
      push_text("AT&c1P=\"x\",e"); push_eol();
      push_char(8'hFF); push_eol();
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      while (beats_made < 1750) begin
         if ($urandom_range(0, 29) == 0) push_char("A", 1'b1);
         else push_line();
      end
      push_eol();
      // let everything drain
      while (pending_beats.size() != 0 || req_valid || expected_records.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d lines, %0d commands, %0d error lines, %0d repeat lines",
               lines_seen, commands_seen, error_lines, repeat_lines);
      if (error_count == 0 && expected_records.size() == 0) begin
         $display("[at_command_line_parser_unit] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[at_command_line_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
